>>> rtl/core/local_alignment_path_dp_defines.svh
// Assertion macros for the local alignment path block.
// Used by files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef LOCAL_ALIGNMENT_PATH_DP_DEFINES_SVH
`define LOCAL_ALIGNMENT_PATH_DP_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define LAD_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, idle during reset.
`define LAD_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> rtl/core/lad_pkg.sv
// Shared constants for the local alignment path block.
// No dependencies.
package lad_pkg;

    localparam logic signed [31:0] NEG_ONE = -32'sd256;   // -1.0 in Q8.8
    localparam logic signed [31:0] THRESH  = 32'sd25;     // 0.1 in Q8.8, rounded down

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic CFG_LEN_A = 1'b0;
    localparam logic CFG_LEN_B = 1'b1;

endpackage

>>> rtl/core/lad_cell.sv
// One column cell of the rotating column-state chain.
// Depends on lad_pkg for the clear value.
module lad_cell #(
    parameter int PW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_clear,
    input  logic                 i_shift,
    input  logic                 i_take_push,
    input  logic signed [31:0]   i_nb_dp,
    input  logic signed [31:0]   i_nb_cm,
    input  logic [PW-1:0]        i_nb_cmr,
    input  logic signed [31:0]   i_push_dp,
    input  logic signed [31:0]   i_push_cm,
    input  logic [PW-1:0]        i_push_cmr,
    output logic signed [31:0]   o_dp,
    output logic signed [31:0]   o_cm,
    output logic [PW-1:0]        o_cmr
);

    logic signed [31:0] r_dp;
    logic signed [31:0] r_cm;
    logic [PW-1:0]      r_cmr;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_dp  <= lad_pkg::NEG_ONE;
            r_cm  <= lad_pkg::NEG_ONE;
            r_cmr <= '0;
        end else if (i_shift) begin
            if (i_take_push) begin
                r_dp  <= i_push_dp;
                r_cm  <= i_push_cm;
                r_cmr <= i_push_cmr;
            end else begin
                r_dp  <= i_nb_dp;
                r_cm  <= i_nb_cm;
                r_cmr <= i_nb_cmr;
            end
        end
    end

    assign o_dp  = r_dp;
    assign o_cm  = r_cm;
    assign o_cmr = r_cmr;

endmodule

>>> rtl/core/local_alignment_path_dp.sv
// Local alignment path finder: similarity memory, column-cell chain, traceback.
// Depends on lad_pkg, lad_cell and local_alignment_path_dp_defines.svh.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready     | i_op, i_row_index, i_col_index, i_cell_value
//  output   | o_out_valid / i_out_ready   | o_pos_a, o_pos_b, o_best_score,
//           |                             | o_path_found, o_last
//  config   | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// A run fills the table one cell per cycle through the chain head, picks the start cell in
// S_DECIDE, then posts a no-path result from S_NOPATH or traces back one pair per
// S_TB_RD/S_TB_CHK pass, a split set by the registered reads of the similarity and skip
// memories.
// Synchronous active-low reset; memories are not cleared.
// One item at a time: o_in_ready is low from run start until its last result is loaded.
// Output stalls hold the traceback; the result register frees the input side.
`include "local_alignment_path_dp_defines.svh"

module local_alignment_path_dp #(
    parameter int MAX_LEN = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [6:0]          i_row_index,
    input  logic [6:0]          i_col_index,
    input  logic signed [15:0]  i_cell_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [6:0]          o_pos_a,
    output logic [6:0]          o_pos_b,
    output logic signed [31:0]  o_best_score,
    output logic                o_path_found,
    output logic                o_last,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [6:0]          i_cfg_data
);

    localparam int DIM = MAX_LEN + 2;
    localparam int PW  = $clog2(DIM);
    localparam int TW  = PW + 2;
    localparam int SA  = $clog2(MAX_LEN * MAX_LEN);
    localparam int KA  = $clog2(DIM * DIM);
    localparam int CW  = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_DECIDE, S_NOPATH, S_TB_RD, S_TB_CHK, S_TB_FIN
    } t_state;

    t_state r_state;

    logic [6:0]    r_len_a, r_len_b;
    logic [PW-1:0] r_na, r_nb;

    logic signed [15:0] sim_mem [MAX_LEN*MAX_LEN];
    logic signed [TW-1:0] skip_mem [DIM*DIM];
    logic signed [15:0] r_sim_q;
    logic signed [TW-1:0] r_skip_q;

    // fill stage A
    logic          r_a_on;
    logic [PW-1:0] r_ai, r_aj;
    // fill stage B
    logic          r_b_valid, r_b_inr;
    logic [PW-1:0] r_bi, r_bj;
    logic signed [31:0] r_prev_v, r_rowmax;
    logic [PW-1:0] r_rowmax_at;
    logic signed [31:0] r_best;
    logic [PW-1:0] r_best_row, r_best_col;

    // traceback
    logic [PW-1:0] r_ci, r_cj, r_pi, r_pj;
    logic          r_t_inr, r_have_pend;
    logic [CW-1:0] r_n;

    // output register
    logic          r_o_valid, r_o_found, r_o_last;
    logic [6:0]    r_o_a, r_o_b;
    logic signed [31:0] r_o_score;

    // chain
    logic signed [31:0] w_dp  [MAX_LEN+1];
    logic signed [31:0] w_cm  [MAX_LEN+1];
    logic [PW-1:0]      w_cmr [MAX_LEN+1];

    logic          w_run_start, w_load;
    logic signed [31:0] n_push_dp, n_push_cm;
    logic [PW-1:0] n_push_cmr;

    // len clamps
    function automatic logic [PW-1:0] clamp_len(input logic [6:0] v);
        logic [PW-1:0] res;
        if (v == 7'd0) res = PW'(1);
        else if (32'(v) > MAX_LEN) res = PW'(MAX_LEN);
        else res = PW'(v);
        return res;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_load      = i_in_valid && o_in_ready && (i_op == lad_pkg::OP_LOAD);
    assign w_run_start = i_in_valid && o_in_ready && (i_op == lad_pkg::OP_RUN);

    // ---------------- similarity memory ----------------
    logic          w_load_ok;
    logic [SA-1:0] w_load_addr, w_rd_addr;
    logic [PW-1:0] w_rd_r, w_rd_c;
    logic          w_rd_en;

    assign w_load_ok = (i_row_index != 7'd0) && (i_col_index != 7'd0) &&
                       (32'(i_row_index) <= MAX_LEN) && (32'(i_col_index) <= MAX_LEN);
    assign w_load_addr = SA'((32'(i_row_index) - 1) * MAX_LEN + (32'(i_col_index) - 1));
    assign w_rd_r  = (r_state == S_FILL) ? r_ai : r_ci;
    assign w_rd_c  = (r_state == S_FILL) ? r_aj : r_cj;
    assign w_rd_addr = SA'((32'(w_rd_r) - 1) * MAX_LEN + (32'(w_rd_c) - 1));
    assign w_rd_en = ((r_state == S_FILL) && r_a_on) || (r_state == S_TB_RD);

    always_ff @(posedge i_clk) begin
        if (w_load && w_load_ok) begin
            sim_mem[w_load_addr] <= i_cell_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_sim_q <= sim_mem[w_rd_addr];
        end
    end

    // ---------------- cell computation at the chain head ----------------
    logic signed [31:0] w_rm, w_col, w_row, w_maxv, w_v;
    logic [PW-1:0]      w_rm_at;
    logic               w_col_win, w_row_win;
    logic signed [TW-1:0] w_cop, w_rop, w_top;
    logic signed [15:0] w_cell;
    logic signed [32:0] w_sum;
    logic               w_b_first, w_b_last;

    always_comb begin
        w_b_first = (r_bj == PW'(1));
        w_b_last  = (r_bi == r_nb + PW'(1)) && (r_bj == r_na + PW'(1));
        w_rm      = w_b_first ? lad_pkg::NEG_ONE : r_rowmax;
        w_rm_at   = w_b_first ? '0 : r_rowmax_at;
        w_cell    = r_b_inr ? r_sim_q : 16'sd0;

        w_col_win = w_cm[0] > w_dp[0];
        w_col = w_col_win ? w_cm[0] : 32'sd0;
        w_cop = w_col_win ? $signed(TW'(r_bi)) - $signed(TW'(w_cmr[0])) - TW'(1) : '0;

        w_row_win = w_rm > w_dp[0];
        w_row = w_row_win ? w_rm : 32'sd0;
        w_rop = w_row_win ? $signed(TW'(w_rm_at)) + TW'(1) - $signed(TW'(r_bj)) : '0;

        w_maxv = w_dp[0];
        w_top  = '0;
        if (w_row > w_maxv) begin
            w_maxv = w_row;
            w_top  = w_rop;
        end
        if (w_col > w_maxv) begin
            w_maxv = w_col;
            w_top  = w_cop;
        end

        w_sum = 33'(w_cell) + 33'(w_maxv);
        if (w_sum[32] != w_sum[31]) w_v = w_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else w_v = w_sum[31:0];

        n_push_dp  = w_b_first ? lad_pkg::NEG_ONE : r_prev_v;
        n_push_cm  = w_col_win ? w_cm[0] : w_dp[0];
        n_push_cmr = w_col_win ? w_cmr[0] : r_bi - PW'(1);
    end

    genvar k;
    generate
        for (k = 0; k <= MAX_LEN; k++) begin : g_chain
            if (k == MAX_LEN) begin : g_tail
                lad_cell #(.PW(PW)) u_cell (
                    .i_clk      (i_clk),
                    .i_clear    (w_run_start),
                    .i_shift    (r_b_valid),
                    .i_take_push(1'b1),
                    .i_nb_dp    (n_push_dp),
                    .i_nb_cm    (n_push_cm),
                    .i_nb_cmr   (n_push_cmr),
                    .i_push_dp  (n_push_dp),
                    .i_push_cm  (n_push_cm),
                    .i_push_cmr (n_push_cmr),
                    .o_dp       (w_dp[k]),
                    .o_cm       (w_cm[k]),
                    .o_cmr      (w_cmr[k])
                );
            end else begin : g_body
                lad_cell #(.PW(PW)) u_cell (
                    .i_clk      (i_clk),
                    .i_clear    (w_run_start),
                    .i_shift    (r_b_valid),
                    .i_take_push(r_na == PW'(k)),
                    .i_nb_dp    (w_dp[k+1]),
                    .i_nb_cm    (w_cm[k+1]),
                    .i_nb_cmr   (w_cmr[k+1]),
                    .i_push_dp  (n_push_dp),
                    .i_push_cm  (n_push_cm),
                    .i_push_cmr (n_push_cmr),
                    .o_dp       (w_dp[k]),
                    .o_cm       (w_cm[k]),
                    .o_cmr      (w_cmr[k])
                );
            end
        end
    endgenerate

    // ---------------- skip memory ----------------
    logic [KA-1:0] w_skip_waddr, w_skip_raddr;

    assign w_skip_waddr = KA'(32'(r_bi) * DIM + 32'(r_bj));
    assign w_skip_raddr = KA'(32'(r_ci) * DIM + 32'(r_cj));

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            skip_mem[w_skip_waddr] <= w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TB_RD) begin
            r_skip_q <= skip_mem[w_skip_raddr];
        end
    end

    // ---------------- traceback helpers ----------------
    logic               w_can_load, w_neg, w_term;
    logic signed [TW-1:0] w_ni, w_nj;

    always_comb begin
        w_can_load = !r_o_valid || i_out_ready;
        w_neg  = r_t_inr && r_sim_q[15];
        w_term = (r_ci <= PW'(1)) || (r_cj <= PW'(1)) || (32'(r_n) == MAX_LEN - 1);
        w_ni = $signed(TW'(r_ci));
        w_nj = $signed(TW'(r_cj));
        if (r_skip_q > 0) w_ni = w_ni - r_skip_q;
        else if (r_skip_q < 0) w_nj = w_nj + r_skip_q;
        w_ni = w_ni - TW'(1);
        w_nj = w_nj - TW'(1);
        if (w_ni < 0) w_ni = '0;
        if (w_nj < 0) w_nj = '0;
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len_a     <= 7'd64;
            r_len_b     <= 7'd64;
            r_a_on      <= 1'b0;
            r_b_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_have_pend <= 1'b0;
            r_n         <= '0;
            r_best      <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lad_pkg::CFG_LEN_A: r_len_a <= i_cfg_data;
                    lad_pkg::CFG_LEN_B: r_len_b <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_o_valid && i_out_ready) r_o_valid <= 1'b0;

            // stage A
            r_b_valid <= r_a_on;
            if (r_a_on) begin
                r_bi    <= r_ai;
                r_bj    <= r_aj;
                r_b_inr <= (r_ai <= r_nb) && (r_aj <= r_na);
                if (r_aj == r_na + PW'(1)) begin
                    r_aj <= PW'(1);
                    r_ai <= r_ai + PW'(1);
                    if (r_ai == r_nb + PW'(1)) r_a_on <= 1'b0;
                end else begin
                    r_aj <= r_aj + PW'(1);
                end
            end

            // stage B
            if (r_b_valid) begin
                r_prev_v    <= w_v;
                r_rowmax    <= w_row_win ? w_rm : w_dp[0];
                r_rowmax_at <= w_row_win ? w_rm_at : r_bj - PW'(1);
                if (w_v > r_best) begin
                    r_best     <= w_v;
                    r_best_row <= r_bi;
                    r_best_col <= r_bj;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_run_start) begin
                        r_na       <= clamp_len(r_len_a);
                        r_nb       <= clamp_len(r_len_b);
                        r_ai       <= PW'(1);
                        r_aj       <= PW'(1);
                        r_a_on     <= 1'b1;
                        r_best     <= '0;
                        r_best_row <= '0;
                        r_best_col <= '0;
                        r_state    <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_b_valid && w_b_last) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_n         <= '0;
                    r_have_pend <= 1'b0;
                    r_ci        <= r_best_row;
                    r_cj        <= r_best_col;
                    r_state     <= (r_best > lad_pkg::THRESH) ? S_TB_RD : S_NOPATH;
                end
                S_NOPATH: begin
                    if (w_can_load) begin
                        r_o_valid <= 1'b1;
                        r_o_a     <= '0;
                        r_o_b     <= '0;
                        r_o_score <= r_best;
                        r_o_found <= 1'b0;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_TB_RD: begin
                    r_t_inr <= (r_ci != '0) && (r_cj != '0) && (r_ci <= r_nb) && (r_cj <= r_na);
                    r_state <= S_TB_CHK;
                end
                S_TB_CHK: begin
                    if (w_neg) begin
                        if (w_can_load) begin
                            r_o_valid <= 1'b1;
                            r_o_a     <= r_have_pend ? 7'(r_pj) : 7'd0;
                            r_o_b     <= r_have_pend ? 7'(r_pi) : 7'd0;
                            r_o_score <= r_best;
                            r_o_found <= r_have_pend;
                            r_o_last  <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end else if (!r_have_pend || w_can_load) begin
                        if (r_have_pend) begin
                            r_o_valid <= 1'b1;
                            r_o_a     <= 7'(r_pj);
                            r_o_b     <= 7'(r_pi);
                            r_o_score <= r_best;
                            r_o_found <= 1'b1;
                            r_o_last  <= 1'b0;
                        end
                        r_pi        <= r_ci;
                        r_pj        <= r_cj;
                        r_have_pend <= 1'b1;
                        r_n         <= r_n + CW'(1);
                        if (w_term) begin
                            r_state <= S_TB_FIN;
                        end else begin
                            r_ci    <= PW'(w_ni);
                            r_cj    <= PW'(w_nj);
                            r_state <= S_TB_RD;
                        end
                    end
                end
                S_TB_FIN: begin
                    if (w_can_load) begin
                        r_o_valid <= 1'b1;
                        r_o_a     <= 7'(r_pj);
                        r_o_b     <= 7'(r_pi);
                        r_o_score <= r_best;
                        r_o_found <= 1'b1;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_pos_a      = r_o_a;
    assign o_pos_b      = r_o_b;
    assign o_best_score = r_o_score;
    assign o_path_found = r_o_found;
    assign o_last       = r_o_last;

    `LAD_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_pos_a) && $stable(o_pos_b) && $stable(o_best_score) &&
        $stable(o_path_found) && $stable(o_last), "result changed while stalled")
    `LAD_ASSERT_IMP(a_nopath_is_last, o_out_valid && !o_path_found, o_last,
        "no-path result not marked last")
    `LAD_ASSERT_IMP(a_path_over_thresh, o_out_valid && o_path_found,
        o_best_score > lad_pkg::THRESH, "path reported at low score")

endmodule
